// ----- hw/rtl/spra_pkg.sv -----
// ----------------------------------------------------------------------------
// spra_pkg
// Shared types and constants for the SPI register access master.
// ----------------------------------------------------------------------------
package spra_pkg;

  localparam int FRAME_BITS = 24;
  localparam int BIT_W      = $clog2(FRAME_BITS + 1);
  localparam int CNT_W      = 16;
  localparam int WORD_W     = 16;
  localparam int ADDR_W     = 7;
  localparam int CFG_IDX_W  = 8;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_PERIOD = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_DELAY = 8'd1;

  localparam logic [CNT_W-1:0] HALF_PERIOD_RST = 16'd5;
  localparam logic [CNT_W-1:0] START_DELAY_RST = 16'd500;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_START = 2'd1,
    PH_LOW   = 2'd2,
    PH_HIGH  = 2'd3
  } phase_t;

endpackage

// ----- hw/rtl/spra_if.sv -----
// ----------------------------------------------------------------------------
// spra channel interfaces
// Valid/ready channels for tick beats, result beats and register writes.
// ----------------------------------------------------------------------------
interface spra_in_if;
  logic        valid;
  logic        ready;
  logic        go;
  logic        op;
  logic [6:0]  reg_address;
  logic [15:0] write_data;
  logic        new_block;
  logic        miso_in;

  modport source (output valid, go, op, reg_address, write_data, new_block, miso_in,
                  input ready);
  modport sink   (input valid, go, op, reg_address, write_data, new_block, miso_in,
                  output ready);
endinterface

interface spra_out_if;
  logic        valid;
  logic        ready;
  logic        sclk_out;
  logic        mosi_out;
  logic        busy_res;
  logic        done_res;
  logic [15:0] read_data;
  logic [15:0] checksum;

  modport source (output valid, sclk_out, mosi_out, busy_res, done_res, read_data,
                  checksum, input ready);
  modport sink   (input valid, sclk_out, mosi_out, busy_res, done_res, read_data,
                  checksum, output ready);
endinterface

interface spra_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- hw/rtl/spi_register_access_master_core.sv -----
// ----------------------------------------------------------------------------
// spi_register_access_master_core
// SPI master for 16-bit register reads and writes with a running checksum.
// ----------------------------------------------------------------------------
// Each input beat is one time tick of the serial waveform and yields exactly
// one result beat showing the line and status state after that tick. A beat
// is taken every clock cycle: the tick logic is a single pass from the state
// registers into the result register, and the input stays ready while a
// result waits, provided the result register is free or is being taken in
// the same cycle. Each result beat is valid in the cycle after its tick is taken. On a
// go tick in idle the clock drops for start_delay_ticks ticks (counting the
// go tick), then 24 bits go out MSB first: address byte (bit 7 set for a
// read) and 16 data bits, each as a low half and a high half of
// half_period_ticks ticks. MISO is sampled on the last tick of each low
// half. A zero register value behaves as one. Registers should be written
// only while no access is running; the write port is always ready.
// ----------------------------------------------------------------------------
module spi_register_access_master_core
  import spra_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  spra_in_if.sink   in_ch,
  spra_out_if.source out_ch,
  spra_cfg_if.sink  cfg_ch
);

  // configuration
  logic [CNT_W-1:0]  half_period_r;
  logic [CNT_W-1:0]  start_delay_r;

  // serial engine state
  phase_t            phase_r, phase_nxt;
  logic [CNT_W-1:0]  tick_r, tick_nxt;
  logic [BIT_W-1:0]  bit_idx_r, bit_idx_nxt;
  logic [BIT_W-1:0]  bit_idx_inc;
  logic [FRAME_BITS-1:0] out_shift_r, out_shift_nxt;
  logic [WORD_W-1:0] in_shift_r, in_shift_nxt;
  logic              is_read_r, is_read_nxt;
  logic [7:0]        sum_r, sum_nxt;
  logic [7:0]        xor_r, xor_nxt;
  logic              sclk_r, sclk_nxt;
  logic              mosi_r, mosi_nxt;
  logic [WORD_W-1:0] last_read_r, last_read_nxt;
  logic              done_nxt;
  logic [WORD_W-1:0] word;

  // result register
  logic              out_valid_r;
  logic              done_r;
  logic              busy_r;

  logic in_fire;

  assign in_ch.ready  = !out_valid_r || out_ch.ready;
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  // register writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_period_r <= HALF_PERIOD_RST;
      start_delay_r <= START_DELAY_RST;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        CFG_HALF_PERIOD: half_period_r <= cfg_ch.data;
        CFG_START_DELAY: start_delay_r <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // word that goes into the checksum: received word for a read, the sent
  // word (back in the low bits after a full rotation) for a write
  assign word        = is_read_r ? in_shift_r : out_shift_r[WORD_W-1:0];
  assign bit_idx_inc = bit_idx_r + 1'b1;

  always_comb begin
    phase_nxt     = phase_r;
    tick_nxt      = tick_r;
    bit_idx_nxt   = bit_idx_r;
    out_shift_nxt = out_shift_r;
    in_shift_nxt  = in_shift_r;
    is_read_nxt   = is_read_r;
    sum_nxt       = sum_r;
    xor_nxt       = xor_r;
    sclk_nxt      = sclk_r;
    mosi_nxt      = mosi_r;
    last_read_nxt = last_read_r;
    done_nxt      = 1'b0;
    unique case (phase_r)
      PH_IDLE: begin
        if (in_ch.go) begin
          is_read_nxt   = in_ch.op;
          out_shift_nxt = {in_ch.op, in_ch.reg_address,
                           in_ch.op ? {WORD_W{1'b0}} : in_ch.write_data};
          in_shift_nxt  = '0;
          bit_idx_nxt   = '0;
          if (in_ch.new_block) begin
            sum_nxt = '0;
            xor_nxt = '0;
          end
          sclk_nxt  = 1'b0;
          tick_nxt  = CNT_W'(1);
          phase_nxt = PH_START;
        end
      end
      PH_START: begin
        if (tick_r >= start_delay_r) begin
          sclk_nxt  = 1'b0;
          mosi_nxt  = out_shift_r[FRAME_BITS-1];
          tick_nxt  = CNT_W'(1);
          phase_nxt = PH_LOW;
        end else begin
          tick_nxt = tick_r + 1'b1;
        end
      end
      PH_LOW: begin
        if (tick_r >= half_period_r) begin
          // sample and rotate; clock rises
          in_shift_nxt  = {in_shift_r[WORD_W-2:0], in_ch.miso_in};
          out_shift_nxt = {out_shift_r[FRAME_BITS-2:0], out_shift_r[FRAME_BITS-1]};
          sclk_nxt      = 1'b1;
          tick_nxt      = CNT_W'(1);
          phase_nxt     = PH_HIGH;
        end else begin
          tick_nxt = tick_r + 1'b1;
        end
      end
      PH_HIGH: begin
        if (tick_r >= half_period_r) begin
          bit_idx_nxt = bit_idx_inc;
          if (bit_idx_inc >= BIT_W'(FRAME_BITS)) begin
            if (is_read_r) last_read_nxt = in_shift_r;
            sum_nxt   = sum_r + word[7:0] + word[15:8];
            xor_nxt   = xor_r ^ word[7:0] ^ word[15:8];
            tick_nxt  = '0;
            phase_nxt = PH_IDLE;
            done_nxt  = 1'b1;
          end else begin
            sclk_nxt  = 1'b0;
            mosi_nxt  = out_shift_r[FRAME_BITS-1];
            tick_nxt  = CNT_W'(1);
            phase_nxt = PH_LOW;
          end
        end else begin
          tick_nxt = tick_r + 1'b1;
        end
      end
      default: ;
    endcase
  end

  // state advances once per accepted tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      tick_r      <= '0;
      bit_idx_r   <= '0;
      out_shift_r <= '0;
      in_shift_r  <= '0;
      is_read_r   <= 1'b0;
      sum_r       <= '0;
      xor_r       <= '0;
      sclk_r      <= 1'b1;
      mosi_r      <= 1'b1;
      last_read_r <= '0;
    end else if (in_fire) begin
      phase_r     <= phase_nxt;
      tick_r      <= tick_nxt;
      bit_idx_r   <= bit_idx_nxt;
      out_shift_r <= out_shift_nxt;
      in_shift_r  <= in_shift_nxt;
      is_read_r   <= is_read_nxt;
      sum_r       <= sum_nxt;
      xor_r       <= xor_nxt;
      sclk_r      <= sclk_nxt;
      mosi_r      <= mosi_nxt;
      last_read_r <= last_read_nxt;
    end
  end

  // result beat: held until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      done_r <= done_nxt;
      busy_r <= (phase_nxt != PH_IDLE);
    end
  end

  // line and status fields mirror the state after the last accepted tick
  assign out_ch.valid     = out_valid_r;
  assign out_ch.sclk_out  = sclk_r;
  assign out_ch.mosi_out  = mosi_r;
  assign out_ch.busy_res  = busy_r;
  assign out_ch.done_res  = done_r;
  assign out_ch.read_data = last_read_r;
  assign out_ch.checksum  = {xor_r, sum_r};

endmodule

// ----- hw/rtl/spra_checker.sv -----
// ----------------------------------------------------------------------------
// spra_checker
// Port-level checks for the SPI register access master, bound to the core.
// ----------------------------------------------------------------------------
module spra_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        sclk_out,
  input logic        mosi_out,
  input logic        busy_res,
  input logic        done_res,
  input logic [15:0] read_data,
  input logic [15:0] checksum
);

  // a completing beat never reports busy
  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && done_res |-> !busy_res)
    else $error("done beat reports busy");

  // clock idles high outside an access
  a_idle_clk_high: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !busy_res |-> sclk_out)
    else $error("clock low while idle");

  // input is taken whenever the result register is free
  a_ready_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable({sclk_out, mosi_out, busy_res,
                                                     done_res, read_data, checksum}))
    else $error("stalled result beat changed");

  // a beat taken with no input beat leaves the result register empty
  a_out_drain: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !in_valid |=> !out_valid)
    else $error("result beat repeated");

endmodule

bind spi_register_access_master_core spra_checker u_spra_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .sclk_out  (out_ch.sclk_out),
  .mosi_out  (out_ch.mosi_out),
  .busy_res  (out_ch.busy_res),
  .done_res  (out_ch.done_res),
  .read_data (out_ch.read_data),
  .checksum  (out_ch.checksum)
);
